@@ hdl/smax_pkg.sv @@
package smax_pkg;

  localparam int unsigned ACT_W   = 16;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned EXP_W   = 17;
  localparam int unsigned DIFF_W  = 17;
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned REM_W   = SUM_W + 1;
  localparam int unsigned QUO_W   = PROB_W + 1;
  localparam int unsigned DIV_CNT_W = 5;

  // Clamp limit 20.0 in Q5.12 and half of it for index rounding
  localparam logic [DIFF_W-1:0] CLAMP_Q12 = 17'd81920;
  localparam logic [DIFF_W-1:0] HALF_Q12  = 17'd40960;
  // 81920 = 2^14 * 5; divide by 5 as multiply by ceil(2^18 / 5)
  localparam int unsigned DIV5_SHIFT = 18;
  localparam logic [15:0] RECIP5     = 16'd52429;
  localparam int unsigned POW2_SHIFT = 14;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [ACT_W-1:0] ACT_MIN = {1'b1, {(ACT_W-1){1'b0}}};

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic signed [ACT_W-1:0] activation;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [PROB_W-1:0] probability;
    logic [COL_W-1:0]  winner;
    logic              row_end;
  } out_word_t;

  // exp(-f) in Q2.30 for 0 <= f <= 1.0, twenty truncated Taylor terms
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = Q30_ONE;
    neg  = 64'd0;
    term = Q30_ONE;
    term = ((term * f) >> 30) / 64'd1;  neg += term;
    term = ((term * f) >> 30) / 64'd2;  pos += term;
    term = ((term * f) >> 30) / 64'd3;  neg += term;
    term = ((term * f) >> 30) / 64'd4;  pos += term;
    term = ((term * f) >> 30) / 64'd5;  neg += term;
    term = ((term * f) >> 30) / 64'd6;  pos += term;
    term = ((term * f) >> 30) / 64'd7;  neg += term;
    term = ((term * f) >> 30) / 64'd8;  pos += term;
    term = ((term * f) >> 30) / 64'd9;  neg += term;
    term = ((term * f) >> 30) / 64'd10; pos += term;
    term = ((term * f) >> 30) / 64'd11; neg += term;
    term = ((term * f) >> 30) / 64'd12; pos += term;
    term = ((term * f) >> 30) / 64'd13; neg += term;
    term = ((term * f) >> 30) / 64'd14; pos += term;
    term = ((term * f) >> 30) / 64'd15; neg += term;
    term = ((term * f) >> 30) / 64'd16; pos += term;
    term = ((term * f) >> 30) / 64'd17; neg += term;
    term = ((term * f) >> 30) / 64'd18; pos += term;
    term = ((term * f) >> 30) / 64'd19; neg += term;
    term = ((term * f) >> 30) / 64'd20; pos += term;
    return (pos > neg) ? (pos - neg) : 64'd0;
  endfunction

  // Table entry for argument t in Q34.30 (0..20.0): Q1.16, rounded
  function automatic logic [EXP_W-1:0] exp_entry(input logic [63:0] t);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] e1;
    n  = t >> 30;
    r  = exp_neg_frac(t & (Q30_ONE - 64'd1));
    e1 = exp_neg_frac(Q30_ONE);
    for (int j = 0; j < 20; j++) begin
      if (64'(j) < n) r = (r * e1) >> 30;
    end
    return EXP_W'((r * 64'd65536 + (Q30_ONE >> 1)) >> 30);
  endfunction

endpackage

@@ hdl/smax_if.sv @@
interface smax_in_if;
  logic                valid;
  logic                ready;
  smax_pkg::in_word_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface smax_out_if;
  logic                valid;
  logic                ready;
  smax_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/softmax_argmax_row.sv @@
// Clamped softmax with argmax over one row of class activations. Words carry
// signed Q4.12 activations; each one is taken while ready is high and stored,
// up to MAX_CLASSES per row (further columns are dropped, the last flag still
// ends the row). After the word flagged last the block drops ready and walks
// the stored row twice through one shared lookup path (buffer read, clamped
// difference, index multiply, divide-by-five multiply, exp table read): the
// first pass builds the sum of the table values, the second forms each
// probability from the path output by the bit-serial restoring divider, one
// quotient bit at a time, and then waits in the output step while a stalled
// sink holds the output register. Results leave in column order; winner is
// the first column holding the strictly greatest activation and row_end
// marks the final column.
module softmax_argmax_row #(
  parameter int unsigned MAX_CLASSES     = 16,
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  smax_in_if.sink          in_i,
  smax_out_if.source       out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int unsigned CI_W  = $clog2(MAX_CLASSES);
  localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned X_W   = smax_pkg::DIFF_W + IDX_W + 1;
  localparam int unsigned Y_W   = X_W - smax_pkg::POW2_SHIFT;
  localparam int unsigned P_W   = Y_W + 16;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_IDX  = 4'd4;
  localparam logic [3:0] S_ROM  = 4'd5;
  localparam logic [3:0] S_EXP  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic PH_SUM  = 1'b0;
  localparam logic PH_EMIT = 1'b1;

  // Exp table, built at elaboration
  logic [smax_pkg::EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] TQ = ((64'(gi) * 64'd20) << 30) / 64'(EXP_TABLE_DEPTH - 1);
    assign exp_rom[gi] = smax_pkg::exp_entry(TQ);
  end

  logic [smax_pkg::ACT_W-1:0] row_mem [MAX_CLASSES];

  logic [3:0]                  state_q;
  logic                        phase_q;
  logic [CNT_W-1:0]            count_q;
  logic [CNT_W-1:0]            col_q;
  logic signed [smax_pkg::ACT_W-1:0] max_q;
  logic [CI_W-1:0]             best_q;
  logic [smax_pkg::SUM_W-1:0]  sum_q;

  logic signed [smax_pkg::ACT_W-1:0] rd_data_q;
  logic [smax_pkg::DIFF_W-1:0] d_q;
  logic [X_W-1:0]              x_q;
  logic [IDX_W-1:0]            idx_q;
  logic [smax_pkg::EXP_W-1:0]  exp_q;

  logic [smax_pkg::REM_W-1:0]  rem_q;
  logic [smax_pkg::QUO_W-1:0]  quo_q;
  logic [smax_pkg::DIV_CNT_W-1:0] div_cnt_q;

  logic                        out_valid_q;
  smax_pkg::out_word_t         out_word_q;

  logic                        in_acc;
  logic signed [smax_pkg::ACT_W-1:0] act;
  logic                        row_full;
  logic                        mem_we;
  logic                        col_last;
  logic                        out_free;
  logic                        out_load;
  logic signed [smax_pkg::DIFF_W-1:0] diff_s;
  logic [smax_pkg::DIFF_W-1:0] diff_c;
  logic [Y_W-1:0]              y_val;
  logic [P_W-1:0]              div5_prod;
  logic [smax_pkg::SUM_W:0]    sum_add;
  logic                        div_ge;
  logic [smax_pkg::REM_W-1:0]  div_sub;
  logic [CNT_W+3:0]            col_ext;
  logic [CI_W+3:0]             best_ext;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign act        = $signed(in_i.payload.activation);
  assign row_full   = (count_q >= CNT_W'(MAX_CLASSES));
  assign mem_we     = in_acc && !row_full;
  assign col_last   = (col_q == count_q - CNT_W'(1));
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == S_OUT) && out_free;

  // max_q bounds every stored value, so the difference is never negative
  assign diff_s = $signed({max_q[smax_pkg::ACT_W-1], max_q})
                - $signed({rd_data_q[smax_pkg::ACT_W-1], rd_data_q});
  assign diff_c = (unsigned'(diff_s) > smax_pkg::CLAMP_Q12) ? smax_pkg::CLAMP_Q12
                                                            : unsigned'(diff_s);

  assign y_val     = x_q[X_W-1:smax_pkg::POW2_SHIFT];
  assign div5_prod = P_W'(y_val) * P_W'(smax_pkg::RECIP5);

  assign sum_add = {1'b0, sum_q} + (smax_pkg::SUM_W + 1)'(exp_q);

  assign div_ge  = rem_q >= smax_pkg::REM_W'(sum_q);
  assign div_sub = rem_q - smax_pkg::REM_W'(sum_q);

  assign col_ext  = {4'b0, col_q};
  assign best_ext = {4'b0, best_q};

  // Row buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[count_q[CI_W-1:0]] <= act;
    rd_data_q <= $signed(row_mem[col_q[CI_W-1:0]]);
  end

  // Shared lookup path, one stage per sequencer step
  always_ff @(posedge clk_i) begin
    d_q   <= diff_c;
    x_q   <= X_W'(d_q) * X_W'(EXP_TABLE_DEPTH - 1) + X_W'(smax_pkg::HALF_Q12);
    idx_q <= div5_prod[smax_pkg::DIV5_SHIFT +: IDX_W];
    exp_q <= exp_rom[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      phase_q   <= PH_SUM;
      count_q   <= '0;
      col_q     <= '0;
      max_q     <= $signed(smax_pkg::ACT_MIN);
      best_q    <= '0;
      sum_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (!row_full) begin
              if (count_q == '0 || act > max_q) begin
                max_q  <= act;
                best_q <= count_q[CI_W-1:0];
              end
              count_q <= count_q + CNT_W'(1);
            end
            if (in_i.payload.last) begin
              state_q <= S_RD;
              phase_q <= PH_SUM;
              col_q   <= '0;
              sum_q   <= '0;
            end
          end
        end
        S_RD:   state_q <= S_DIFF;
        S_DIFF: state_q <= S_MUL;
        S_MUL:  state_q <= S_IDX;
        S_IDX:  state_q <= S_ROM;
        S_ROM:  state_q <= S_EXP;
        S_EXP: begin
          if (phase_q == PH_SUM) begin
            sum_q <= sum_add[smax_pkg::SUM_W] ? smax_pkg::SUM_MAX
                                              : sum_add[smax_pkg::SUM_W-1:0];
            if (col_last) begin
              phase_q <= PH_EMIT;
              col_q   <= '0;
            end else begin
              col_q <= col_q + CNT_W'(1);
            end
            state_q <= S_RD;
          end else begin
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + smax_pkg::DIV_CNT_W'(1);
          if (div_cnt_q == smax_pkg::DIV_CNT_W'(smax_pkg::QUO_W - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (col_last) begin
              state_q <= S_LOAD;
              count_q <= '0;
              max_q   <= $signed(smax_pkg::ACT_MIN);
              best_q  <= '0;
              sum_q   <= '0;
              col_q   <= '0;
            end else begin
              col_q   <= col_q + CNT_W'(1);
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Restoring divider: one quotient bit a cycle, integer bit first
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXP) begin
      rem_q <= smax_pkg::REM_W'(exp_q);
      quo_q <= '0;
    end else if (state_q == S_DIV) begin
      rem_q <= div_ge ? {div_sub[smax_pkg::REM_W-2:0], 1'b0}
                      : {rem_q[smax_pkg::REM_W-2:0], 1'b0};
      quo_q <= {quo_q[smax_pkg::QUO_W-2:0], div_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q.column      <= col_ext[3:0];
      // saturate a probability of exactly one
      out_word_q.probability <= quo_q[smax_pkg::QUO_W-1] ? {smax_pkg::PROB_W{1'b1}}
                                                         : quo_q[smax_pkg::PROB_W-1:0];
      out_word_q.winner      <= best_ext[3:0];
      out_word_q.row_end     <= col_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

  a_last_drops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.payload.last) |=> !in_i.ready)
    else $error("ready still high after the last word of a row");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CLASSES))
    else $error("column count beyond capacity");

  a_sum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (sum_q != '0))
    else $error("division started with an empty sum");

  a_row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && col_last) |=> (state_q == S_LOAD && count_q == '0))
    else $error("row state not cleared after the final result");

  a_div_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_OUT) |-> (phase_q == PH_EMIT))
    else $error("divider running outside the emit pass");

endmodule

@@ tb/sv/softmax_row_checker.sv @@
module softmax_row_checker (
  input  logic clk_i,
  input  logic rst_ni,
  smax_in_if   act_mon,
  smax_out_if  prob_mon,
  output int   mismatches_o,
  output int   words_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_CAP      = 16;
  localparam int unsigned LUT_DEPTH    = 256;
  localparam int          DIFF_CLAMP   = 81920;
  localparam int unsigned EXP_SUM_CAP  = (1 << 21) - 1;
  localparam logic [63:0] ONE_Q30      = 64'd1 << 30;

  logic [16:0]         exp_q16_lut [LUT_DEPTH];
  logic signed [15:0]  row_acts [ROW_CAP];
  int unsigned         cols_held;
  logic signed [15:0]  row_peak;
  logic [3:0]          lead_col;
  smax_pkg::out_word_t probs_due [$];
  int                  mismatches;
  int                  words_due;

  assign mismatches_o = mismatches;
  assign words_due_o  = words_due;

  // exp(-f) in Q2.30, twenty truncated Taylor terms
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    term  = ONE_Q30;
    plus  = ONE_Q30;
    minus = 64'd0;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if (k % 2 == 1) minus += term;
      else plus += term;
    end
    return (plus > minus) ? plus - minus : 64'd0;
  endfunction

  initial begin : build_lut
    logic [63:0] e_one;
    logic [63:0] arg;
    logic [63:0] whole;
    logic [63:0] r;
    e_one = exp_neg_q30(ONE_Q30);
    for (int i = 0; i < LUT_DEPTH; i++) begin
      arg   = (64'(20 * i) << 30) / 64'(LUT_DEPTH - 1);
      whole = arg >> 30;
      r     = exp_neg_q30(arg & (ONE_Q30 - 64'd1));
      for (int j = 0; 64'(j) < whole; j++) r = (r * e_one) >> 30;
      exp_q16_lut[i] = 17'((r * 64'd65536 + (ONE_Q30 >> 1)) >> 30);
    end
  end

  function automatic logic [16:0] exp_weight(input logic signed [15:0] v);
    int          d;
    int unsigned idx;
    d = int'(row_peak) - int'(v);
    if (d > DIFF_CLAMP) d = DIFF_CLAMP;
    idx = (d * (LUT_DEPTH - 1) + DIFF_CLAMP / 2) / DIFF_CLAMP;
    if (idx > LUT_DEPTH - 1) idx = LUT_DEPTH - 1;
    return exp_q16_lut[idx];
  endfunction

  function automatic void predict_row_probs();
    int unsigned         row_exp_sum;
    logic [63:0]         q;
    smax_pkg::out_word_t w;
    row_exp_sum = 0;
    for (int c = 0; c < cols_held; c++) begin
      row_exp_sum += exp_weight(row_acts[c]);
      if (row_exp_sum > EXP_SUM_CAP) row_exp_sum = EXP_SUM_CAP;
    end
    for (int c = 0; c < cols_held; c++) begin
      q = 64'd0;
      if (row_exp_sum != 0) begin
        q = (64'(exp_weight(row_acts[c])) << 16) / 64'(row_exp_sum);
        if (q > 64'd65535) q = 64'd65535;
      end
      w.column      = 4'(c);
      w.probability = q[15:0];
      w.winner      = lead_col;
      w.row_end     = (c + 1 == cols_held);
      probs_due.insert(probs_due.size(), w);
    end
    cols_held = 0;
    row_peak  = 16'sh8000;
    lead_col  = '0;
  endfunction

  function automatic void take_activation(input smax_pkg::in_word_t w);
    logic signed [15:0] act;
    act = w.activation;
    // drop columns beyond the row capacity, but still honour the last flag
    if (cols_held < ROW_CAP) begin
      row_acts[cols_held] = act;
      if (cols_held == 0 || act > row_peak) begin
        row_peak = act;
        lead_col = 4'(cols_held);
      end
      cols_held++;
    end
    if (w.last) predict_row_probs();
  endfunction

  function automatic void check_prob_word(input smax_pkg::out_word_t got);
    smax_pkg::out_word_t want;
    if (probs_due.size() == 0) begin
      $error("unexpected word: column %0d probability %0d winner %0d row_end %0d",
             got.column, got.probability, got.winner, got.row_end);
      mismatches++;
      return;
    end
    want = probs_due.pop_front();
    if (got.column !== want.column) begin
      $error("column: expected %0d, got %0d", want.column, got.column);
      mismatches++;
    end
    if (got.probability !== want.probability) begin
      $error("probability: expected %0d, got %0d", want.probability, got.probability);
      mismatches++;
    end
    if (got.winner !== want.winner) begin
      $error("winner: expected %0d, got %0d", want.winner, got.winner);
      mismatches++;
    end
    if (got.row_end !== want.row_end) begin
      $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
      mismatches++;
    end
  endfunction

  initial begin
    cols_held  = 0;
    row_peak   = 16'sh8000;
    lead_col   = '0;
    mismatches = 0;
    words_due  = 0;
  end

  // results first: a word leaving now never stems from one arriving now
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (prob_mon.valid && prob_mon.ready) check_prob_word(prob_mon.payload);
      if (act_mon.valid && act_mon.ready) take_activation(act_mon.payload);
    end
    words_due = probs_due.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mix_e;
  typedef enum int {FULL_RANGE, CLUSTERED, NEAR_TIES, REPEATS} row_style_e;

  localparam int RANDOM_WORDS = 300;
  localparam int LONG_STALL   = 600;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  int        mismatches;
  int        words_due;
  idle_mix_e idle_mix = IDLE_RX_HEAVY;
  bit        stall_req = 1'b0;
  int        random_words = 0;

  smax_in_if  act_if ();
  smax_out_if prob_if ();

  softmax_argmax_row dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (act_if),
    .out_o  (prob_if)
  );

  softmax_row_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .act_mon      (act_if),
    .prob_mon     (prob_if),
    .mismatches_o (mismatches),
    .words_due_o  (words_due)
  );

  always #2 clk_i = ~clk_i;

  function automatic int tx_idle_pct();
    case (idle_mix)
      IDLE_RX_HEAVY: return 33;
      IDLE_TX_HEAVY: return 52;
      default:       return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (idle_mix)
      IDLE_RX_HEAVY: return 52;
      IDLE_TX_HEAVY: return 33;
      default:       return 0;
    endcase
  endfunction

  task automatic send_word(input logic signed [15:0] act, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct()) begin
      act_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    act_if.valid   <= 1'b1;
    act_if.payload <= '{activation: act, last: is_last};
    // ready is stable by the falling edge; the word goes at the next rising one
    @(negedge clk_i);
    while (!act_if.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_random_row();
    int                 len;
    int                 pick;
    int                 base;
    int                 spread;
    int                 v;
    row_style_e         style;
    logic signed [15:0] act;
    logic signed [15:0] prev;
    pick = $urandom_range(99);
    if (pick < 8) len = $urandom_range(20, 17);
    else if (pick < 20) len = $urandom_range(2, 1);
    else len = $urandom_range(16, 1);
    style = row_style_e'($urandom_range(3));
    base  = int'($urandom_range(65535)) - 32768;
    case ($urandom_range(2))
      0:       spread = 8;
      1:       spread = 600;
      default: spread = 12000;
    endcase
    prev = 16'(base);
    for (int c = 0; c < len; c++) begin
      case (style)
        FULL_RANGE: act = 16'($urandom);
        CLUSTERED: begin
          v = base + int'($urandom_range(2 * spread)) - spread;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          act = 16'(v);
        end
        NEAR_TIES: begin
          v = base - int'($urandom_range(40));
          if (v < -32768) v = -32768;
          act = ($urandom_range(2) == 0) ? 16'(base) : 16'(v);
        end
        default: act = (c == 0 || $urandom_range(3) == 0) ? 16'($urandom) : prev;
      endcase
      prev = act;
      send_word(act, c == len - 1);
    end
    random_words += len;
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin : take_side
    int stall_left;
    bit stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    prob_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        prob_if.ready <= 1'b0;
        stall_left--;
      end else if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        stall_left = LONG_STALL;
        prob_if.ready <= 1'b0;
      end else begin
        prob_if.ready <= ($urandom_range(99) >= rx_idle_pct());
      end
    end
  end

  initial begin
    #3ms;
    $display("[softmax_argmax_row] ERROR");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    act_if.valid   <= 1'b0;
    act_if.payload <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single column: probability saturates
    send_word(16'sh7FFF, 1'b1);
    // widest spread between the extremes
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b1);
    // three-way tie at the most negative value: earliest column wins
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b1);
    // full row, peak in the final stored column, then a larger word to be dropped
    for (int c = 0; c < 16; c++) send_word(16'(c * c * 120 - 20000), 1'b0);
    send_word(16'sh7FFF, 1'b1);

    while (random_words < RANDOM_WORDS) begin
      if (random_words >= 2 * RANDOM_WORDS / 3 && idle_mix != IDLE_NONE) begin
        idle_mix  = IDLE_NONE;
        stall_req = 1'b1;
      end else if (random_words >= RANDOM_WORDS / 3 && idle_mix == IDLE_RX_HEAVY) begin
        idle_mix = IDLE_TX_HEAVY;
      end
      send_random_row();
    end
    act_if.valid <= 1'b0;

    @(negedge clk_i);
    while (words_due != 0) @(negedge clk_i);
    // catch stray words after the last expected one
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[softmax_argmax_row] OK");
    end else begin
      $display("[softmax_argmax_row] ERROR");
    end
    $finish;
  end

endmodule
